@@ rtl/grsm_pkg.sv @@
package grsm_pkg;

  // modulus and derived constants
  localparam logic [29:0] PRIME_M = 30'd1000000007;
  localparam logic [29:0] INV_EXP = PRIME_M - 30'd2;
  localparam int unsigned EXP_WIDTH_DEF = 62;

  // Barrett factor floor(2^60 / M) and 2^31 mod M
  localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];
  localparam logic [63:0] TWO31_WIDE = (64'd1 << 31) % 64'd1000000007;
  localparam logic [29:0] TWO31_MOD = TWO31_WIDE[29:0];

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT_AM,
    ST_INIT,
    ST_POW,
    ST_DRAIN,
    ST_DIFF,
    ST_WAIT_U1,
    ST_UNIT2,
    ST_WAIT_SUM,
    ST_FINISH
  } state_e;

  // issue slots of one square-and-multiply round
  typedef enum logic [2:0] {
    SL_SQ_TOP,
    SL_SQ_BOT,
    SL_SQ_INV,
    SL_MUL_TOP,
    SL_MUL_BOT,
    SL_MUL_INV
  } slot_e;

  // writeback destination of a product
  typedef enum logic [2:0] {
    DST_AM,
    DST_BT,
    DST_BB,
    DST_BI,
    DST_AT,
    DST_AB,
    DST_AI,
    DST_SUM
  } dst_e;

  typedef struct packed {
    logic        vld;
    logic        wen;
    dst_e        dst;
    logic [31:0] x;
    logic [29:0] y;
  } mul_req_t;

  typedef struct packed {
    logic        vld;
    logic        wen;
    dst_e        dst;
    logic [29:0] data;
    logic        busy;
  } mul_rsp_t;

endpackage

@@ rtl/grsm_modmul.sv @@
module grsm_modmul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grsm_pkg::mul_req_t  req_i,
  output grsm_pkg::mul_rsp_t  rsp_o
);
  import grsm_pkg::*;

  localparam int unsigned NSTG = 5;
  localparam logic [31:0] P32  = 32'(PRIME_M);
  localparam logic [31:0] TWO_P = 32'(PRIME_M) + 32'(PRIME_M);

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] wen_q;
  dst_e            dst_q [NSTG];

  logic [31:0] x0_q;
  logic [29:0] y0_q;
  logic [59:0] prod1;
  logic [59:0] p1_q;
  logic [61:0] prod2;
  logic [30:0] q2_q;
  logic [31:0] plo2_q;
  logic [31:0] prod3;
  logic [31:0] qp3_q;
  logic [31:0] plo3_q;
  logic [31:0] r4_q;
  logic [31:0] r_fix;

  // stage 1: full product, below 2^60 for every use
  assign prod1 = 60'(x0_q) * 60'(y0_q);
  // stage 2: quotient estimate
  assign prod2 = 62'(p1_q[59:29]) * 62'(BARRETT_MU);
  // stage 3: quotient times modulus, low word only
  assign prod3 = 32'(q2_q) * P32;

  // valid, write enable and destination travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], req_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    wen_q    <= {wen_q[NSTG-2:0], req_i.wen};
    dst_q[0] <= req_i.dst;
    for (int i = 1; i < NSTG; i++) begin
      dst_q[i] <= dst_q[i-1];
    end
    x0_q   <= req_i.x;
    y0_q   <= req_i.y;
    p1_q   <= prod1;
    q2_q   <= prod2[61:31];
    plo2_q <= p1_q[31:0];
    qp3_q  <= prod3;
    plo3_q <= plo2_q;
    r4_q   <= plo3_q - qp3_q;
  end

  // remainder is below 3M: at most two subtractions
  always_comb begin
    if (r4_q >= TWO_P) begin
      r_fix = r4_q - TWO_P;
    end else if (r4_q >= P32) begin
      r_fix = r4_q - P32;
    end else begin
      r_fix = r4_q;
    end
  end

  assign rsp_o.vld  = vld_q[NSTG-1];
  assign rsp_o.wen  = wen_q[NSTG-1];
  assign rsp_o.dst  = dst_q[NSTG-1];
  assign rsp_o.data = r_fix[29:0];
  assign rsp_o.busy = |vld_q;

endmodule

@@ rtl/geometric_range_sum_mod_prime.sv @@
// Geometric range sum modulo 1000000007.
// Input channel (in_valid_i / in_ready_o) takes one beat: base_value_i and the
// exponent range range_low_i..range_high_i. Output channel (out_valid_o /
// out_ready_i) returns one beat per input: sum_mod_o, and range_error_o when
// range_low_i exceeds range_high_i (sum is then 0).
// All products run through one pipelined Barrett modular multiplier with
// five register stages. The three powers (a^(hi+1), a^lo, (a-1)^(M-2)) are
// interleaved on it in rounds of six issue slots, one exponent bit per round.
// A general base runs one round per bit of the longest of the three
// exponents; base 1 takes the term count hi-lo+1 mod M through the multiplier
// instead, and base 0 and empty ranges skip the multiplier. in_ready_o is
// high only while the sequencer is idle, which it reaches in the cycle after
// loading a result: one item at a time.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a second result waits in the sequencer until the
// receiver takes the first. Reset empties the pipeline and the output.
module geometric_range_sum_mod_prime #(
  parameter int unsigned EXP_WIDTH = grsm_pkg::EXP_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          base_value_i,
  input  logic [EXP_WIDTH-1:0] range_low_i,
  input  logic [EXP_WIDTH-1:0] range_high_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [29:0]          sum_mod_o,
  output logic                 range_error_o
);
  import grsm_pkg::*;

  localparam int unsigned NW = EXP_WIDTH + 1;

  state_e state_q, state_d;
  slot_e  slot_q, slot_d;
  logic   out_valid_q, out_valid_d;

  logic [31:0]          base_q, base_d;
  logic [EXP_WIDTH-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [30:0]          n_lo_q, n_lo_d;
  logic [29:0]          am_q, am_d;
  logic [29:0]          bt_q, bt_d, bb_q, bb_d, bi_q, bi_d;
  logic [29:0]          at_q, at_d, ab_q, ab_d, ai_q, ai_d;
  logic [NW-1:0]        et_q, et_d;
  logic [EXP_WIDTH-1:0] eb_q, eb_d;
  logic [29:0]          ei_q, ei_d;
  logic [29:0]          sum_q, sum_d;
  logic                 err_q, err_d;
  logic [29:0]          out_sum_q, out_sum_d;
  logic                 out_err_q, out_err_d;

  mul_req_t req;
  mul_rsp_t rsp;

  logic [NW-1:0] n_cnt;
  logic [62:0]   n_ext;
  logic [30:0]   diff_w;
  logic          range_gt;
  logic          exp_done;

  // term count for the unit base, split at bit 31 for the reduction
  assign n_cnt    = {1'b0, hi_q} - {1'b0, lo_q} + NW'(1);
  assign n_ext    = 63'(n_cnt);
  assign range_gt = lo_q > hi_q;
  assign exp_done = (et_q == '0) && (eb_q == '0) && (ei_q == '0);

  // (top - bot) mod M
  assign diff_w = (at_q >= ab_q) ? ({1'b0, at_q} - {1'b0, ab_q})
                                 : ({1'b0, at_q} + {1'b0, PRIME_M} - {1'b0, ab_q});

  grsm_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // sequencer and operand registers
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    base_d      = base_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    n_lo_d      = n_lo_q;
    am_d        = am_q;
    bt_d        = bt_q;
    bb_d        = bb_q;
    bi_d        = bi_q;
    at_d        = at_q;
    ab_d        = ab_q;
    ai_d        = ai_q;
    et_d        = et_q;
    eb_d        = eb_q;
    ei_d        = ei_q;
    sum_d       = sum_q;
    err_d       = err_q;
    out_sum_d   = out_sum_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    req.vld     = 1'b0;
    req.wen     = 1'b0;
    req.dst     = DST_AM;
    req.x       = '0;
    req.y       = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          base_d  = base_value_i;
          lo_d    = range_low_i;
          hi_d    = range_high_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        err_d = range_gt;
        sum_d = '0;
        if (range_gt || base_q == 32'd0) begin
          state_d = ST_FINISH;
        end else if (base_q == 32'd1) begin
          // high part times 2^31 mod M
          req.vld = 1'b1;
          req.wen = 1'b1;
          req.dst = DST_AT;
          req.x   = n_ext[62:31];
          req.y   = TWO31_MOD;
          n_lo_d  = n_ext[30:0];
          state_d = ST_WAIT_U1;
        end else begin
          // reduce the base: a * 1 mod M
          req.vld = 1'b1;
          req.wen = 1'b1;
          req.dst = DST_AM;
          req.x   = base_q;
          req.y   = 30'd1;
          state_d = ST_WAIT_AM;
        end
      end
      ST_WAIT_AM: begin
        if (rsp.vld) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        bt_d    = am_q;
        bb_d    = am_q;
        bi_d    = (am_q == '0) ? (PRIME_M - 30'd1) : (am_q - 30'd1);
        at_d    = 30'd1;
        ab_d    = 30'd1;
        ai_d    = 30'd1;
        et_d    = {1'b0, hi_q} + NW'(1);
        eb_d    = lo_q;
        ei_d    = INV_EXP;
        slot_d  = SL_SQ_TOP;
        state_d = ST_POW;
      end
      ST_POW: begin
        if (slot_q == SL_SQ_TOP && exp_done) begin
          state_d = ST_DRAIN;
        end else begin
          req.vld = 1'b1;
          case (slot_q)
            SL_SQ_TOP: begin
              req.wen = 1'b1;
              req.dst = DST_BT;
              req.x   = 32'(bt_q);
              req.y   = bt_q;
              slot_d  = SL_SQ_BOT;
            end
            SL_SQ_BOT: begin
              req.wen = 1'b1;
              req.dst = DST_BB;
              req.x   = 32'(bb_q);
              req.y   = bb_q;
              slot_d  = SL_SQ_INV;
            end
            SL_SQ_INV: begin
              req.wen = 1'b1;
              req.dst = DST_BI;
              req.x   = 32'(bi_q);
              req.y   = bi_q;
              slot_d  = SL_MUL_TOP;
            end
            SL_MUL_TOP: begin
              req.wen = et_q[0];
              req.dst = DST_AT;
              req.x   = 32'(at_q);
              req.y   = bt_q;
              slot_d  = SL_MUL_BOT;
            end
            SL_MUL_BOT: begin
              req.wen = eb_q[0];
              req.dst = DST_AB;
              req.x   = 32'(ab_q);
              req.y   = bb_q;
              slot_d  = SL_MUL_INV;
            end
            SL_MUL_INV: begin
              req.wen = ei_q[0];
              req.dst = DST_AI;
              req.x   = 32'(ai_q);
              req.y   = bi_q;
              slot_d  = SL_SQ_TOP;
              // end of round: next exponent bit
              et_d    = et_q >> 1;
              eb_d    = eb_q >> 1;
              ei_d    = ei_q >> 1;
            end
            default: begin
              req.vld = 1'b0;
              slot_d  = SL_SQ_TOP;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (!rsp.busy) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        req.vld = 1'b1;
        req.wen = 1'b1;
        req.dst = DST_SUM;
        req.x   = 32'(diff_w[29:0]);
        req.y   = ai_q;
        state_d = ST_WAIT_SUM;
      end
      ST_WAIT_U1: begin
        if (rsp.vld) begin
          state_d = ST_UNIT2;
        end
      end
      ST_UNIT2: begin
        // fold in the low part: (hi part + lo part) * 1 mod M
        req.vld = 1'b1;
        req.wen = 1'b1;
        req.dst = DST_SUM;
        req.x   = 32'(at_q) + 32'(n_lo_q);
        req.y   = 30'd1;
        state_d = ST_WAIT_SUM;
      end
      ST_WAIT_SUM: begin
        if (rsp.vld) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_sum_d   = sum_q;
          out_err_d   = err_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // product writeback
    if (rsp.vld && rsp.wen) begin
      case (rsp.dst)
        DST_AM:  am_d  = rsp.data;
        DST_BT:  bt_d  = rsp.data;
        DST_BB:  bb_d  = rsp.data;
        DST_BI:  bi_d  = rsp.data;
        DST_AT:  at_d  = rsp.data;
        DST_AB:  ab_d  = rsp.data;
        DST_AI:  ai_d  = rsp.data;
        DST_SUM: sum_d = rsp.data;
        default: sum_d = sum_q;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= SL_SQ_TOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    n_lo_q    <= n_lo_d;
    am_q      <= am_d;
    bt_q      <= bt_d;
    bb_q      <= bb_d;
    bi_q      <= bi_d;
    at_q      <= at_d;
    ab_q      <= ab_d;
    ai_q      <= ai_d;
    et_q      <= et_d;
    eb_q      <= eb_d;
    ei_q      <= ei_d;
    sum_q     <= sum_d;
    err_q     <= err_d;
    out_sum_q <= out_sum_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign sum_mod_o     = out_sum_q;
  assign range_error_o = out_err_q;

endmodule

@@ rtl/grsm_checker.sv @@
module grsm_checker #(
  parameter int unsigned EXP_WIDTH = grsm_pkg::EXP_WIDTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [31:0]          base_value_i,
  input logic [EXP_WIDTH-1:0] range_low_i,
  input logic [EXP_WIDTH-1:0] range_high_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [29:0]          sum_mod_o,
  input logic                 range_error_o
);
  import grsm_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(sum_mod_o) && $stable(range_error_o))
    else $error("output beat changed while stalled");

  // empty range always reports a zero sum
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> sum_mod_o == '0)
    else $error("range error with nonzero sum");

  // sum is a reduced residue
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sum_mod_o < PRIME_M)
    else $error("sum not reduced");

  // one item at a time: busy right after an accepted input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

endmodule

bind geometric_range_sum_mod_prime grsm_checker #(
  .EXP_WIDTH (EXP_WIDTH)
) u_grsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .base_value_i  (base_value_i),
  .range_low_i   (range_low_i),
  .range_high_i  (range_high_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .sum_mod_o     (sum_mod_o),
  .range_error_o (range_error_o)
);
